### design/mp2d_pkg.sv
// mp2d_pkg: shared constants, types and register codes for the 2d max pooling unit
// no dependencies; compile first
`default_nettype none

package mp2d_pkg;

   localparam int CHANNELS    = 4;
   localparam int MAX_HEIGHT  = 32;
   localparam int MAX_WIDTH   = 32;
   localparam int MAX_WINDOW  = 8;
   localparam int SAMPLE_BITS = 16;

   // payload field widths
   localparam int PLANE_BITS = 2;
   localparam int ROW_BITS   = 5;
   localparam int COL_BITS   = 5;

   // sample store addressing: (plane * MAX_HEIGHT + row) * MAX_WIDTH + col
   localparam int CH_ABITS    = $clog2(CHANNELS);
   localparam int HT_ABITS    = $clog2(MAX_HEIGHT);
   localparam int WD_ABITS    = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS   = CH_ABITS + HT_ABITS + WD_ABITS;
   localparam int STORE_DEPTH = CHANNELS * MAX_HEIGHT * MAX_WIDTH;

   // register widths
   localparam int SIZE_BITS      = 6;
   localparam int WIN_BITS       = 4;
   localparam int STEP_BITS      = 4;
   localparam int PAD_BITS       = 3;
   localparam int CSR_DATA_BITS  = 6;
   localparam int CSR_INDEX_BITS = 3;

   // window counters and signed origin arithmetic
   localparam int KIDX_BITS = $clog2(MAX_WINDOW);
   localparam int ORG_BITS  = ROW_BITS + STEP_BITS + 1;

   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_HEIGHT  = 3'd0,
      REG_IMAGE_WIDTH   = 3'd1,
      REG_WINDOW_HEIGHT = 3'd2,
      REG_WINDOW_WIDTH  = 3'd3,
      REG_STEP_ROWS     = 3'd4,
      REG_STEP_COLS     = 3'd5,
      REG_PAD_ABOVE     = 3'd6,
      REG_PAD_LEFTSIDE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] image_height;
      logic [SIZE_BITS-1:0] image_width;
      logic [WIN_BITS-1:0]  window_height;
      logic [WIN_BITS-1:0]  window_width;
      logic [STEP_BITS-1:0] step_rows;
      logic [STEP_BITS-1:0] step_cols;
      logic [PAD_BITS-1:0]  pad_above;
      logic [PAD_BITS-1:0]  pad_leftside;
   } cfg_type;

   // one window position issued by the scanner
   typedef struct packed {
      logic valid;
      logic first;
      logic rd;
      logic last;
   } step_type;

endpackage

`default_nettype wire

### design/mp2d_if.sv
// mp2d_req_if and mp2d_rsp_if: valid/ready channels of the 2d max pooling unit
// depends on mp2d_pkg
`default_nettype none

interface mp2d_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  kind;
   logic [mp2d_pkg::PLANE_BITS-1:0]       plane;
   logic [mp2d_pkg::ROW_BITS-1:0]         row_pos;
   logic [mp2d_pkg::COL_BITS-1:0]         col_pos;
   logic signed [mp2d_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, kind, plane, row_pos, col_pos, sample, input ready);
   modport sink   (input valid, kind, plane, row_pos, col_pos, sample, output ready);
endinterface

interface mp2d_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [mp2d_pkg::SAMPLE_BITS-1:0] maximum;
   logic                                    empty_window;

   modport source (output valid, maximum, empty_window, input ready);
   modport sink   (input valid, maximum, empty_window, output ready);
endinterface

`default_nettype wire

### design/mp2d_sample_ram.sv
// mp2d_sample_ram: generic one-write one-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module mp2d_sample_ram #(
   parameter int DEPTH     = 4096,
   parameter int WIDTH     = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output      logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### design/mp2d_scan.sv
// mp2d_scan: takes input transfers, writes samples and walks the pooling window
// depends on mp2d_pkg and mp2d_req_if
`default_nettype none

module mp2d_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mp2d_pkg::cfg_type             cfg,
   mp2d_req_if.sink                           req,
   input  wire logic                          busy,
   output      logic                          ram_we,
   output      logic [mp2d_pkg::ADDR_BITS-1:0] ram_waddr,
   output      logic [mp2d_pkg::SAMPLE_BITS-1:0] ram_wdata,
   output      logic                          ram_re,
   output      logic [mp2d_pkg::ADDR_BITS-1:0] ram_raddr,
   output      mp2d_pkg::step_type            step
);

   typedef enum logic {IDLE, SCAN} state_type;

   state_type                            state_ff, state_in;
   logic [mp2d_pkg::CH_ABITS-1:0]        plane_ff, plane_in;
   logic signed [mp2d_pkg::ORG_BITS-1:0] oy_ff, oy_in, ox_ff, ox_in;
   logic [mp2d_pkg::KIDX_BITS-1:0]       ky_ff, ky_in, kx_ff, kx_in;
   logic [mp2d_pkg::WIN_BITS-1:0]        kh_ff, kh_in, kw_ff, kw_in;
   logic [mp2d_pkg::SIZE_BITS-1:0]       h_ff, h_in, w_ff, w_in;
   logic                                 none_ff, none_in;
   logic                                 first_ff, first_in;

   logic                                 accept;
   logic                                 plane_ok;
   logic [mp2d_pkg::ORG_BITS-2:0]        prod_y, prod_x;
   logic signed [mp2d_pkg::ORG_BITS-1:0] iy, ix, ky_ext, kx_ext, h_ext, w_ext;
   logic                                 in_bounds, row_end, col_end;

   assign req.ready = (state_ff == IDLE) && !busy;
   assign accept    = req.valid && req.ready;
   assign plane_ok  = 32'(req.plane) < mp2d_pkg::CHANNELS;

   assign ram_we    = accept && (req.kind == mp2d_pkg::KIND_STORE) && plane_ok;
   assign ram_waddr = {req.plane[mp2d_pkg::CH_ABITS-1:0],
                       req.row_pos[mp2d_pkg::HT_ABITS-1:0],
                       req.col_pos[mp2d_pkg::WD_ABITS-1:0]};
   assign ram_wdata = req.sample;

   always_comb begin
      ky_ext    = mp2d_pkg::ORG_BITS'(ky_ff);
      kx_ext    = mp2d_pkg::ORG_BITS'(kx_ff);
      h_ext     = mp2d_pkg::ORG_BITS'(h_ff);
      w_ext     = mp2d_pkg::ORG_BITS'(w_ff);
      iy        = oy_ff + ky_ext;
      ix        = ox_ff + kx_ext;
      in_bounds = !iy[mp2d_pkg::ORG_BITS-1] && (iy < h_ext)
                  && !ix[mp2d_pkg::ORG_BITS-1] && (ix < w_ext);
      row_end   = mp2d_pkg::WIN_BITS'(ky_ff) == kh_ff - mp2d_pkg::WIN_BITS'(1);
      col_end   = mp2d_pkg::WIN_BITS'(kx_ff) == kw_ff - mp2d_pkg::WIN_BITS'(1);

      step.valid = (state_ff == SCAN);
      step.first = first_ff;
      step.rd    = (state_ff == SCAN) && !none_ff && in_bounds;
      step.last  = none_ff || (row_end && col_end);

      ram_re    = step.rd;
      ram_raddr = {plane_ff, iy[mp2d_pkg::HT_ABITS-1:0], ix[mp2d_pkg::WD_ABITS-1:0]};

      prod_y = (mp2d_pkg::ORG_BITS-1)'(req.row_pos)
               * (mp2d_pkg::ORG_BITS-1)'(cfg.step_rows);
      prod_x = (mp2d_pkg::ORG_BITS-1)'(req.col_pos)
               * (mp2d_pkg::ORG_BITS-1)'(cfg.step_cols);

      state_in = state_ff;
      plane_in = plane_ff;
      oy_in    = oy_ff;
      ox_in    = ox_ff;
      ky_in    = ky_ff;
      kx_in    = kx_ff;
      kh_in    = kh_ff;
      kw_in    = kw_ff;
      h_in     = h_ff;
      w_in     = w_ff;
      none_in  = none_ff;
      first_in = first_ff;

      unique case (state_ff)
         IDLE: begin
            if (accept && (req.kind == mp2d_pkg::KIND_REQUEST)) begin
               state_in = SCAN;
               plane_in = req.plane[mp2d_pkg::CH_ABITS-1:0];
               oy_in    = $signed({1'b0, prod_y})
                          - $signed(mp2d_pkg::ORG_BITS'(cfg.pad_above));
               ox_in    = $signed({1'b0, prod_x})
                          - $signed(mp2d_pkg::ORG_BITS'(cfg.pad_leftside));
               kh_in    = (32'(cfg.window_height) > mp2d_pkg::MAX_WINDOW)
                          ? mp2d_pkg::WIN_BITS'(mp2d_pkg::MAX_WINDOW) : cfg.window_height;
               kw_in    = (32'(cfg.window_width) > mp2d_pkg::MAX_WINDOW)
                          ? mp2d_pkg::WIN_BITS'(mp2d_pkg::MAX_WINDOW) : cfg.window_width;
               h_in     = (32'(cfg.image_height) > mp2d_pkg::MAX_HEIGHT)
                          ? mp2d_pkg::SIZE_BITS'(mp2d_pkg::MAX_HEIGHT) : cfg.image_height;
               w_in     = (32'(cfg.image_width) > mp2d_pkg::MAX_WIDTH)
                          ? mp2d_pkg::SIZE_BITS'(mp2d_pkg::MAX_WIDTH) : cfg.image_width;
               none_in  = !plane_ok || (cfg.window_height == '0)
                          || (cfg.window_width == '0);
               ky_in    = '0;
               kx_in    = '0;
               first_in = 1'b1;
            end
         end
         SCAN: begin
            first_in = 1'b0;
            if (step.last) begin
               state_in = IDLE;
            end else if (col_end) begin
               kx_in = '0;
               ky_in = ky_ff + mp2d_pkg::KIDX_BITS'(1);
            end else begin
               kx_in = kx_ff + mp2d_pkg::KIDX_BITS'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         first_ff <= 1'b0;
         none_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         none_ff  <= none_in;
      end
      plane_ff <= plane_in;
      oy_ff    <= oy_in;
      ox_ff    <= ox_in;
      ky_ff    <= ky_in;
      kx_ff    <= kx_in;
      kh_ff    <= kh_in;
      kw_ff    <= kw_in;
      h_ff     <= h_in;
      w_ff     <= w_in;
   end

endmodule

`default_nettype wire

### design/mp2d_reduce.sv
// mp2d_reduce: running maximum over read samples and the result output register
// depends on mp2d_pkg and mp2d_rsp_if
`default_nettype none

module mp2d_reduce (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mp2d_pkg::step_type               step,
   input  wire logic [mp2d_pkg::SAMPLE_BITS-1:0] rdata,
   mp2d_rsp_if.source                            rsp,
   output      logic                             busy
);

   mp2d_pkg::step_type                      step_d_ff;
   logic signed [mp2d_pkg::SAMPLE_BITS-1:0] best_ff, best_in;
   logic                                    empty_ff, empty_in;
   logic                                    pend_ff, pend_in;
   logic                                    out_valid_ff, out_valid_in;
   logic signed [mp2d_pkg::SAMPLE_BITS-1:0] out_max_ff, out_max_in;
   logic                                    out_empty_ff, out_empty_in;

   logic signed [mp2d_pkg::SAMPLE_BITS-1:0] base_best, acc_best, sample;
   logic                                    base_empty, acc_empty, take;
   logic                                    slot_free, load;

   assign busy             = step_d_ff.valid || pend_ff;
   assign rsp.valid        = out_valid_ff;
   assign rsp.maximum      = out_max_ff;
   assign rsp.empty_window = out_empty_ff;

   always_comb begin
      sample     = $signed(rdata);
      base_best  = step_d_ff.first ? $signed(mp2d_pkg::SAMPLE_MIN) : best_ff;
      base_empty = step_d_ff.first || empty_ff;
      take       = step_d_ff.rd && (base_empty || (sample > base_best));
      acc_best   = take ? sample : base_best;
      acc_empty  = base_empty && !step_d_ff.rd;
      slot_free  = !out_valid_ff || rsp.ready;

      best_in      = best_ff;
      empty_in     = empty_ff;
      pend_in      = pend_ff;
      load         = 1'b0;
      out_max_in   = out_max_ff;
      out_empty_in = out_empty_ff;

      if (step_d_ff.valid) begin
         best_in  = acc_best;
         empty_in = acc_empty;
         if (step_d_ff.last) begin
            if (slot_free) begin
               load         = 1'b1;
               out_max_in   = acc_best;
               out_empty_in = acc_empty;
            end else begin
               pend_in = 1'b1;
            end
         end
      end else if (pend_ff && slot_free) begin
         load         = 1'b1;
         pend_in      = 1'b0;
         out_max_in   = best_ff;
         out_empty_in = empty_ff;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_d_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_d_ff    <= step;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      best_ff      <= best_in;
      empty_ff     <= empty_in;
      out_max_ff   <= out_max_in;
      out_empty_ff <= out_empty_in;
   end

endmodule

`default_nettype wire

### design/max_pool_2d_window_unit.sv
// max_pool_2d_window_unit: 2d max pooling over a stored four-channel 32x32 sample plane
// depends on mp2d_pkg, mp2d_if, mp2d_sample_ram, mp2d_scan and mp2d_reduce
//
// req_ch carries two kinds of transfer. A store writes one signed sample at
// plane, row and column into a 4096-entry synchronous ram. A request names a
// plane and an output row and column; the window at (row * step_rows - pad_above,
// col * step_cols - pad_leftside) is read one position per cycle through the
// single ram read port (a single position when the window size is zero). The
// read data and the step are registered together into the reduce stage, whose
// last step loads the rsp_ch output register; req_ch takes no new transfer until
// that last step has left the reduce stage. Positions outside the image give
// no read; a window with no inside position returns the most negative value
// with empty_window set. csr_we/csr_index/csr_wdata write the eight size, window,
// stride and pad registers; the user must write them only while the unit is idle,
// which the block does not enforce. Reset restores the register defaults and
// clears the handshake state; the sample ram is not cleared and needs no pass.
// While rsp_ch is stalled one result waits in the output register and the next
// finished one in the accumulator; req_ch then takes no transfer, stores included,
// until the output register has moved its result.
`default_nettype none

module max_pool_2d_window_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mp2d_req_if.sink                                 req_ch,
   mp2d_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [mp2d_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mp2d_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mp2d_pkg::cfg_type                cfg_ff;
   mp2d_pkg::step_type               step;
   logic                             busy;
   logic                             ram_we, ram_re;
   logic [mp2d_pkg::ADDR_BITS-1:0]   ram_waddr, ram_raddr;
   logic [mp2d_pkg::SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height  <= mp2d_pkg::SIZE_BITS'(32);
         cfg_ff.image_width   <= mp2d_pkg::SIZE_BITS'(32);
         cfg_ff.window_height <= mp2d_pkg::WIN_BITS'(2);
         cfg_ff.window_width  <= mp2d_pkg::WIN_BITS'(2);
         cfg_ff.step_rows     <= mp2d_pkg::STEP_BITS'(1);
         cfg_ff.step_cols     <= mp2d_pkg::STEP_BITS'(1);
         cfg_ff.pad_above     <= '0;
         cfg_ff.pad_leftside  <= '0;
      end else if (csr_we) begin
         unique case (mp2d_pkg::csr_index_type'(csr_index))
            mp2d_pkg::REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            mp2d_pkg::REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            mp2d_pkg::REG_WINDOW_HEIGHT:
               cfg_ff.window_height <= csr_wdata[mp2d_pkg::WIN_BITS-1:0];
            mp2d_pkg::REG_WINDOW_WIDTH:
               cfg_ff.window_width <= csr_wdata[mp2d_pkg::WIN_BITS-1:0];
            mp2d_pkg::REG_STEP_ROWS:
               cfg_ff.step_rows <= csr_wdata[mp2d_pkg::STEP_BITS-1:0];
            mp2d_pkg::REG_STEP_COLS:
               cfg_ff.step_cols <= csr_wdata[mp2d_pkg::STEP_BITS-1:0];
            mp2d_pkg::REG_PAD_ABOVE:
               cfg_ff.pad_above <= csr_wdata[mp2d_pkg::PAD_BITS-1:0];
            mp2d_pkg::REG_PAD_LEFTSIDE:
               cfg_ff.pad_leftside <= csr_wdata[mp2d_pkg::PAD_BITS-1:0];
         endcase
      end
   end

   mp2d_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_ch),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .step      (step)
   );

   mp2d_sample_ram #(
      .DEPTH     (mp2d_pkg::STORE_DEPTH),
      .WIDTH     (mp2d_pkg::SAMPLE_BITS),
      .ADDR_BITS (mp2d_pkg::ADDR_BITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mp2d_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .rdata (ram_rdata),
      .rsp   (rsp_ch),
      .busy  (busy)
   );

endmodule

`default_nettype wire
